FILE: design/spatial_hash_bucket_insert_top_defines.svh
// assertion macros for the spatial hash insert block
`ifndef SPATIAL_HASH_BUCKET_INSERT_TOP_DEFINES_SVH
`define SPATIAL_HASH_BUCKET_INSERT_TOP_DEFINES_SVH

`ifndef SYNTH
`define SHBI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHBI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHBI_ASSERT(label, prop, msg)
`define SHBI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/shbi_pkg.sv
// shared types and constants for the spatial hash insert block
package shbi_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_MAX_PROBES = 1'b1;

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349669;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [16:0] TABLE_SIZE_RST  = 17'd65536;
    localparam logic [6:0]  MAX_PROBES_RST  = 7'd10;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        read_index;
    } shbi_in_t;

    typedef struct packed {
        logic               placed;
        logic [15:0]        slot_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
        logic               entry_used;
        logic [16:0]        inserted_count;
    } shbi_out_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } shbi_coord_t;

    typedef struct packed {
        logic rd;
        logic wr_coord;
        logic wr_used;
        logic used_val;
    } shbi_tbl_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_DIV,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_READ,
        ST_READ_CHK,
        ST_RESP
    } shbi_state_t;

endpackage

FILE: design/shbi_hash.sv
// voxel hash: one shared 32x32 multiplier over the three coordinates
module shbi_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] z,
    output logic        done,
    output logic [31:0] hash
);
    import shbi_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] opnd;
    logic [31:0] prime;

    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                opnd  = x;
                prime = PRIME_X;
            end
            2'd1:
            begin
                opnd  = y;
                prime = PRIME_Y;
            end
            default:
            begin
                opnd  = z;
                prime = PRIME_Z;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 2'd3)
            begin
                prod_reg <= opnd * prime;
            end
            if (cnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg ^ prod_reg;
            end
        end
    end

    assign done = done_reg;
    assign hash = acc_reg;

endmodule

FILE: design/shbi_mod.sv
// restoring remainder unit, one dividend bit per cycle
module shbi_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [16:0] rem
);
    import shbi_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [16:0] div_reg;
    logic [16:0] rem_reg;
    logic [17:0] trial;
    logic [17:0] diff;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= diff[16:0];
            end
            else
            begin
                rem_reg <= trial[16:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/shbi_table.sv
// slot memories: coordinates and used flags, registered reads
module shbi_table #(
    parameter int TABLE_DEPTH = 65536,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                   clk,
    input  shbi_pkg::shbi_tbl_req_t req,
    input  logic [AW-1:0]          addr,
    input  shbi_pkg::shbi_coord_t  wdata,
    output logic                   used_q,
    output shbi_pkg::shbi_coord_t  coord_q
);
    import shbi_pkg::*;

    logic        used_mem [TABLE_DEPTH];
    shbi_coord_t coord_mem [TABLE_DEPTH];
    logic        used_q_reg;
    shbi_coord_t coord_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_used)
        begin
            used_mem[addr] <= req.used_val;
        end
        if (req.rd)
        begin
            used_q_reg <= used_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_coord)
        begin
            coord_mem[addr] <= wdata;
        end
        if (req.rd)
        begin
            coord_q_reg <= coord_mem[addr];
        end
    end

    assign used_q  = used_q_reg;
    assign coord_q = coord_q_reg;

endmodule

FILE: design/spatial_hash_bucket_insert_top.sv
// spatial hash table of voxel coordinates built by linear probing
//
//   port group   handshake             payload
//   in           in_valid / in_ready   in_data  (shbi_in_t)
//   out          out_valid / out_ready out_data (shbi_out_t)
//   cfg          cfg_we                cfg_index, cfg_data
//
// every item is taken in the idle state and leaves through the result stage
// insert: hashing on one shared multiplier, the bit-serial remainder unit,
// then a read and a check per probe on the slot memory port, and one last
// probe read step, with no read, when every probe finds its slot in use
// read, index in range: a read and a check; unknown opcode: nothing more
// after reset and for every clear, a pass writes the used flags of all
// TABLE_DEPTH slots, one a cycle, and in_ready stays low meanwhile
// a finished result waits in the output register while the next item runs
`include "spatial_hash_bucket_insert_top_defines.svh"

module spatial_hash_bucket_insert_top #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  shbi_pkg::shbi_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output shbi_pkg::shbi_out_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data
);
    import shbi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    shbi_state_t   state_reg, state_next;
    shbi_in_t      item_reg;
    shbi_out_t     res_reg;
    shbi_out_t     res_init;
    shbi_out_t     out_reg;
    shbi_out_t     res_full;
    logic          out_valid_reg;
    logic [16:0]   table_size_reg;
    logic [6:0]    max_probes_reg;
    logic [16:0]   count_reg;
    logic [16:0]   size_reg;
    logic [16:0]   size_eff;
    logic [16:0]   b_reg;
    logic [16:0]   b_step;
    logic [16:0]   b_inc;
    logic [31:0]   cur_reg;
    logic [6:0]    probe_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_resp_reg;
    logic          accept;
    logic          out_free;
    logic          read_in_range;
    logic          clr_last;

    logic          hash_start;
    logic          hash_done;
    logic [31:0]   hash_val;
    logic          mod_start;
    logic          mod_done;
    logic [16:0]   mod_rem;

    shbi_tbl_req_t tbl_req;
    logic [AW-1:0] tbl_addr;
    shbi_coord_t   tbl_wdata;
    logic          tbl_used;
    shbi_coord_t   tbl_coord;

    assign accept        = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign read_in_range = ({16'd0, item_reg.read_index} < 32'(TABLE_DEPTH));
    assign clr_last      = (clr_cnt_reg == AW'(TABLE_DEPTH - 1));
    assign b_inc         = 17'(b_reg + 17'd1);
    assign b_step        = ((cur_reg == '1) || (b_inc == size_reg)) ? 17'd0 : b_inc;

    always_comb
    begin
        if (table_size_reg == 17'd0)
        begin
            size_eff = 17'd1;
        end
        else if ({15'd0, table_size_reg} > 32'(TABLE_DEPTH))
        begin
            size_eff = 17'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = table_size_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            max_probes_reg <= MAX_PROBES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                CFG_MAX_PROBES: max_probes_reg <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.opcode)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_INSERT: state_next = ST_HASH;
                        OP_READ:
                        begin
                            if ({16'd0, in_data.read_index} < 32'(TABLE_DEPTH))
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = (probe_reg == max_probes_reg) ? ST_RESP : ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                state_next = tbl_used ? ST_PROBE_RD : ST_RESP;
            end
            ST_READ:
            begin
                state_next = ST_READ_CHK;
            end
            ST_READ_CHK:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        hash_start = 1'b0;
        mod_start  = 1'b0;
        tbl_req    = '0;
        tbl_addr   = AW'(b_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_req.wr_used = 1'b1;
                tbl_addr        = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                hash_start = in_valid && (in_data.opcode == OP_INSERT);
            end
            ST_HASH:
            begin
                mod_start = hash_done;
            end
            ST_PROBE_RD:
            begin
                tbl_req.rd = (probe_reg != max_probes_reg);
            end
            ST_PROBE_CHK:
            begin
                tbl_req.wr_coord = !tbl_used;
                tbl_req.wr_used  = !tbl_used;
                tbl_req.used_val = 1'b1;
            end
            ST_READ:
            begin
                tbl_req.rd = 1'b1;
                tbl_addr   = AW'(item_reg.read_index);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_last)
                    begin
                        clr_resp_reg <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (in_data.opcode == OP_CLEAR))
                    begin
                        count_reg    <= '0;
                        clr_cnt_reg  <= '0;
                        clr_resp_reg <= 1'b1;
                    end
                end
                ST_PROBE_CHK:
                begin
                    if (!tbl_used && (count_reg != COUNT_MAX))
                    begin
                        count_reg <= count_reg + 17'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_init = '0;
        if (in_data.opcode == OP_READ)
        begin
            res_init.slot_index = in_data.read_index;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_data;
                    res_reg  <= res_init;
                    size_reg <= size_eff;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    b_reg     <= mod_rem;
                    cur_reg   <= hash_val;
                    probe_reg <= '0;
                end
            end
            ST_PROBE_CHK:
            begin
                if (tbl_used)
                begin
                    b_reg     <= b_step;
                    cur_reg   <= cur_reg + 32'd1;
                    probe_reg <= probe_reg + 7'd1;
                end
                else
                begin
                    res_reg.placed     <= 1'b1;
                    res_reg.slot_index <= b_reg[15:0];
                end
            end
            ST_READ_CHK:
            begin
                if (read_in_range && tbl_used)
                begin
                    res_reg.entry_used <= 1'b1;
                    res_reg.entry_x    <= tbl_coord.x;
                    res_reg.entry_y    <= tbl_coord.y;
                    res_reg.entry_z    <= tbl_coord.z;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_full                = res_reg;
        res_full.inserted_count = count_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_RESP) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_reg <= res_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign tbl_wdata.x = item_reg.coord_x;
    assign tbl_wdata.y = item_reg.coord_y;
    assign tbl_wdata.z = item_reg.coord_z;

    shbi_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .x     (item_reg.coord_x),
        .y     (item_reg.coord_y),
        .z     (item_reg.coord_z),
        .done  (hash_done),
        .hash  (hash_val)
    );

    shbi_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_val),
        .divisor  (size_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    shbi_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .req     (tbl_req),
        .addr    (tbl_addr),
        .wdata   (tbl_wdata),
        .used_q  (tbl_used),
        .coord_q (tbl_coord)
    );

    `SHBI_ASSERT(a_probe_slot_in_range, (state_reg == ST_PROBE_RD || state_reg == ST_PROBE_CHK) |-> (b_reg < size_reg), "probe slot beyond table size")
    `SHBI_ASSERT(a_probe_count_bound, (state_reg == ST_PROBE_RD || state_reg == ST_PROBE_CHK) |-> (probe_reg <= max_probes_reg), "probe count beyond limit")
    `SHBI_ASSERT(a_hash_done_in_hash, hash_done |-> (state_reg == ST_HASH), "hash finished outside hash phase")
    `SHBI_ASSERT(a_mod_done_in_div, mod_done |-> (state_reg == ST_DIV), "remainder finished outside divide phase")
    `SHBI_ASSERT_NEXT(a_count_step, state_reg == ST_PROBE_CHK && !tbl_used && count_reg != COUNT_MAX, count_reg == $past(count_reg) + 17'd1, "placed count did not advance")

endmodule
